### rtl/bisection_square_root_defines.svh
// assertion macros for the bisection square root block
// used by the top level only; no other dependencies
`ifndef BISECTION_SQUARE_ROOT_DEFINES_SVH
`define BISECTION_SQUARE_ROOT_DEFINES_SVH
`ifndef SYNTH
`define BSQRT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed: same-cycle implication");
`define BSQRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed: next-cycle implication");
`else
`define BSQRT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BSQRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/bsqrt_pkg.sv
// shared types, constants and helpers of the bisection square root block
// no dependencies
`timescale 1ns / 1ps
package bsqrt_pkg;
	localparam int WORD_WIDTH = 32;
	localparam int RAD_WIDTH = WORD_WIDTH - 1;
	localparam int PROD_WIDTH = 2 * WORD_WIDTH;
	localparam int FRAC_BITS = 16;
	localparam int MAX_STEPS = 100;
	localparam int STEP_WIDTH = $clog2(MAX_STEPS + 1);
	localparam int ITER_WIDTH = 7;
	localparam int CFG_DATA_WIDTH = 32;
	localparam int CFG_INDEX_WIDTH = 1;

	localparam logic [ITER_WIDTH-1:0] ITER_RESET = 7'd100;
	localparam logic [WORD_WIDTH-1:0] LOWER_RESET = 32'd6554;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ITERATION_COUNT = 1'b0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOWER_START = 1'b1;

	typedef enum logic [1:0] {
		SIGN_NEG  = 2'd0,
		SIGN_ZERO = 2'd1,
		SIGN_POS  = 2'd2
	} sign_t;

	typedef enum logic [1:0] {
		ST_IDLE     = 2'd0,
		ST_SIGN_LOW = 2'd1,
		ST_MUL      = 2'd2,
		ST_CMP      = 2'd3
	} state_t;

	typedef struct packed {
		logic [ITER_WIDTH-1:0] iteration_count;
		logic [WORD_WIDTH-1:0] lower_start;
	} cfg_t;

	// floor of the exact sum halved
	function automatic logic [WORD_WIDTH-1:0] midpoint(input logic [WORD_WIDTH-1:0] a,
		input logic [WORD_WIDTH-1:0] b);
		logic [WORD_WIDTH:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[WORD_WIDTH:1];
	endfunction
endpackage

### rtl/bsqrt_cfg.sv
// configuration registers: step count and initial lower bound
// depends on bsqrt_pkg
`timescale 1ns / 1ps
module bsqrt_cfg (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [bsqrt_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [bsqrt_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
	output bsqrt_pkg::cfg_t                        cfg
);
	logic [bsqrt_pkg::ITER_WIDTH-1:0] iteration_count_q;
	logic [bsqrt_pkg::WORD_WIDTH-1:0] lower_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iteration_count_q <= bsqrt_pkg::ITER_RESET;
			lower_start_q <= bsqrt_pkg::LOWER_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bsqrt_pkg::REG_ITERATION_COUNT: begin
					iteration_count_q <= cfg_data[bsqrt_pkg::ITER_WIDTH-1:0];
				end
				bsqrt_pkg::REG_LOWER_START: begin
					lower_start_q <= cfg_data[bsqrt_pkg::WORD_WIDTH-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.iteration_count = iteration_count_q;
	assign cfg.lower_start = lower_start_q;
endmodule

### rtl/bsqrt_sqcmp.sv
// shared square-and-compare unit: registers x*x, then gives sign of c - x*x
// depends on bsqrt_pkg
`timescale 1ns / 1ps
module bsqrt_sqcmp (
	input  logic                                clk,
	input  logic                                load,
	input  logic [bsqrt_pkg::WORD_WIDTH-1:0]    x,
	input  logic [bsqrt_pkg::RAD_WIDTH-1:0]     c,
	output bsqrt_pkg::sign_t                    sign
);
	logic [bsqrt_pkg::PROD_WIDTH-1:0] square_q;
	logic [bsqrt_pkg::PROD_WIDTH-1:0] target;

	always_ff @(posedge clk) begin
		if (load) begin
			square_q <= {{bsqrt_pkg::WORD_WIDTH{1'b0}}, x} * {{bsqrt_pkg::WORD_WIDTH{1'b0}}, x};
		end
	end

	// c moved to the same binary point as the square
	assign target = {{(bsqrt_pkg::PROD_WIDTH - bsqrt_pkg::RAD_WIDTH){1'b0}}, c}
		<< bsqrt_pkg::FRAC_BITS;

	always_comb begin
		if (target > square_q) sign = bsqrt_pkg::SIGN_POS;
		else if (target == square_q) sign = bsqrt_pkg::SIGN_ZERO;
		else sign = bsqrt_pkg::SIGN_NEG;
	end
endmodule

### rtl/bisection_square_root.sv
// top level of the bisection square root block: sequencer, interval registers,
// result register; uses bsqrt_cfg, bsqrt_sqcmp, bsqrt_pkg and the defines header
//
//   channel   dir  handshake            payload
//   in        in   in_valid/in_ready    radicand (31b unsigned Q15.16)
//   out       out  out_valid/out_ready  estimate (32b Q16.16), error_bound (32b signed)
//   cfg       in   cfg_we               cfg_index, cfg_data (no read-back)
//
// from accept to out_valid: the sign of the lower bound squared is taken in ST_SIGN_LOW,
// then each of the N steps (N the clamped step count, 1..100) squares the midpoint on
// the shared multiplier in ST_MUL and compares it the cycle after, in ST_CMP
// in_ready is high only while idle, so a new beat is taken only after the last one has
// finished; a finished result waits in the output register and the last step of the next item
// stalls while it is full. reset clears the sequencer and out_valid, loads defaults
`timescale 1ns / 1ps
`include "bisection_square_root_defines.svh"
module bisection_square_root (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [bsqrt_pkg::RAD_WIDTH-1:0]       radicand,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [bsqrt_pkg::WORD_WIDTH-1:0]      estimate,
	output logic signed [bsqrt_pkg::WORD_WIDTH-1:0] error_bound,
	input  logic                                  cfg_we,
	input  logic [bsqrt_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [bsqrt_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
	bsqrt_pkg::cfg_t   cfg;
	bsqrt_pkg::state_t state_q, state_d;
	bsqrt_pkg::sign_t  sign;

	// interval and item registers
	logic [bsqrt_pkg::RAD_WIDTH-1:0]  c_q;
	logic [bsqrt_pkg::WORD_WIDTH-1:0] a_q, b_q, p_q;
	bsqrt_pkg::sign_t                 sa_q;
	logic [bsqrt_pkg::STEP_WIDTH-1:0] count_q;

	// output register
	logic                             out_valid_q;
	logic [bsqrt_pkg::WORD_WIDTH-1:0] estimate_q, error_q;

	logic                             accept, mul_load, take_b, last_step, out_free, finish;
	logic [bsqrt_pkg::WORD_WIDTH-1:0] mul_x, a_new, b_new;
	logic [bsqrt_pkg::WORD_WIDTH:0]   diff;
	logic [7:0]                       iter_ext, steps_clamped;

	bsqrt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bsqrt_sqcmp u_sqcmp (
		.clk  (clk),
		.load (mul_load),
		.x    (mul_x),
		.c    (c_q),
		.sign (sign)
	);

	// a zero step count runs one step, anything past the maximum saturates
	assign iter_ext = {1'b0, cfg.iteration_count};
	always_comb begin
		if (iter_ext == 8'd0) steps_clamped = 8'd1;
		else if (iter_ext > 8'(bsqrt_pkg::MAX_STEPS)) steps_clamped = 8'(bsqrt_pkg::MAX_STEPS);
		else steps_clamped = iter_ext;
	end

	// keep a and move b to p when f(a) and f(p) differ in sign or either is zero
	assign take_b = (sa_q == bsqrt_pkg::SIGN_ZERO) || (sign == bsqrt_pkg::SIGN_ZERO)
		|| (sa_q != sign);
	assign a_new = take_b ? a_q : p_q;
	assign b_new = take_b ? p_q : b_q;
	assign last_step = (count_q == bsqrt_pkg::STEP_WIDTH'(1));
	assign out_free = !out_valid_q || out_ready;

	// width of the final interval; halved and floored into the error bound
	assign diff = {1'b0, b_new} - {1'b0, a_new};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= bsqrt_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		mul_load = 1'b0;
		mul_x = p_q;
		finish = 1'b0;
		case (state_q)
			bsqrt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				mul_x = cfg.lower_start;
				mul_load = in_valid;
				if (in_valid) state_d = bsqrt_pkg::ST_SIGN_LOW;
			end
			bsqrt_pkg::ST_SIGN_LOW: begin
				state_d = bsqrt_pkg::ST_MUL;
			end
			bsqrt_pkg::ST_MUL: begin
				mul_load = 1'b1;
				state_d = bsqrt_pkg::ST_CMP;
			end
			bsqrt_pkg::ST_CMP: begin
				if (!last_step) begin
					state_d = bsqrt_pkg::ST_MUL;
				end else if (out_free) begin
					finish = 1'b1;
					state_d = bsqrt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bsqrt_pkg::ST_IDLE;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			c_q <= radicand;
			a_q <= cfg.lower_start;
			b_q <= {radicand, 1'b0};
			count_q <= bsqrt_pkg::STEP_WIDTH'(steps_clamped);
		end
		if (state_q == bsqrt_pkg::ST_SIGN_LOW) begin
			sa_q <= sign;
			p_q <= bsqrt_pkg::midpoint(a_q, b_q);
		end
		// step update and next midpoint; the last midpoint stays for the result
		if (state_q == bsqrt_pkg::ST_CMP && !last_step) begin
			a_q <= a_new;
			b_q <= b_new;
			p_q <= bsqrt_pkg::midpoint(a_new, b_new);
			count_q <= count_q - bsqrt_pkg::STEP_WIDTH'(1);
		end
		if (finish) begin
			estimate_q <= p_q;
			error_q <= diff[bsqrt_pkg::WORD_WIDTH:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (finish) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign estimate = estimate_q;
	assign error_bound = error_q;

	// an accepted beat always starts a run, so ready drops the next cycle
	`BSQRT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, !in_ready)
	// the step counter stays in range while a run is going
	`BSQRT_ASSERT_SAME(a_count_range, clk, arst_n, state_q == bsqrt_pkg::ST_CMP,
		count_q != '0 && count_q <= bsqrt_pkg::STEP_WIDTH'(bsqrt_pkg::MAX_STEPS))
	// finishing the last step posts a result and frees the input side
	`BSQRT_ASSERT_NEXT(a_finish_posts, clk, arst_n, finish, out_valid && in_ready)
endmodule
